[sv/hrlp_pkg.sv]
`default_nettype none

package hrlp_pkg;

   // One byte of the received request.
   typedef struct packed {
      logic [7:0] req_byte;
      logic       end_of_data;
   } request_type;

   // One result transaction.
   typedef struct packed {
      logic [3:0] status;
      logic [7:0] asset_byte;
      logic       has_byte;
      logic       last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_ROOT               = 4'd0,
      ST_ASSET              = 4'd1,
      ST_METHOD_LONG        = 4'd2,
      ST_PATH_LONG          = 4'd3,
      ST_VERSION_LONG       = 4'd4,
      ST_METHOD_INCOMPLETE  = 4'd5,
      ST_PATH_INCOMPLETE    = 4'd6,
      ST_VERSION_INCOMPLETE = 4'd7,
      ST_NOT_GET            = 4'd8,
      ST_BAD_VERSION        = 4'd9,
      ST_EMPTY_PATH         = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      PH_METHOD  = 2'd0,
      PH_PATH    = 2'd1,
      PH_VERSION = 2'd2,
      PH_DRAIN   = 2'd3
   } phase_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;

   // Longest method and version fields, in characters.
   localparam int METHOD_LIMIT  = 9;
   localparam int VERSION_LIMIT = 11;

   localparam int GET_LEN     = 3;
   localparam int PREFIX_LEN  = 7;
   localparam int VERSION_LEN = 8;

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47;  // G
         2'd1:    c = 8'h45;  // E
         default: c = 8'h54;  // T
      endcase
      return c;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48;  // H
         3'd1:    c = 8'h54;  // T
         3'd2:    c = 8'h54;  // T
         3'd3:    c = 8'h50;  // P
         3'd4:    c = 8'h2F;  // /
         3'd5:    c = 8'h31;  // 1
         default: c = 8'h2E;  // .
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[sv/hrlp_queue.sv]
`default_nettype none

module hrlp_queue #(
   parameter type ENTRY_TYPE = logic,
   parameter int  DEPTH      = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire ENTRY_TYPE                    push_data,
   output logic                              full,
   input  wire logic                         pop,
   output ENTRY_TYPE                         pop_data,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH+1);

   ENTRY_TYPE         store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == LW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/hrlp_front.sv]
`default_nettype none

module hrlp_front #(
   parameter int  ASSET_MAX = 15,
   parameter type CMD_TYPE  = logic,
   parameter type WR_TYPE   = logic
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire hrlp_pkg::request_type req_data,
   input  wire logic                  cmd_full,
   output logic                       cmd_push,
   output CMD_TYPE                    cmd_data,
   output WR_TYPE                     wr,
   input  wire logic                  asset_done
);

   localparam int LEN_W      = $clog2(ASSET_MAX+2);
   localparam int CNT_W      = (LEN_W > 4) ? LEN_W : 4;
   localparam int AW         = $clog2(ASSET_MAX+1);
   localparam int PATH_LIMIT = ASSET_MAX + 1;

   hrlp_pkg::phase_type  phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 match_ff, match_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 pending_ff, pending_in;
   logic                 accept, decided, eod;
   logic [7:0]           b;
   hrlp_pkg::status_type st;

   // The path store belongs to the back end while an asset burst is owed.
   assign full   = cmd_full || (pending_ff && (phase_ff == hrlp_pkg::PH_PATH));
   assign accept = push && !full;
   assign b      = req_data.req_byte;
   assign eod    = req_data.end_of_data;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      match_in   = match_ff;
      len_in     = len_ff;
      pending_in = pending_ff && !asset_done;
      decided    = 1'b0;
      st         = hrlp_pkg::ST_ROOT;
      wr.en      = 1'b0;
      wr.addr    = count_ff[AW-1:0];
      wr.data    = b;

      if (accept) begin
         unique case (phase_ff)
            hrlp_pkg::PH_METHOD: begin
               if (b == hrlp_pkg::CHAR_SPACE) begin
                  if (match_ff && count_ff == CNT_W'(hrlp_pkg::GET_LEN)) begin
                     phase_in = hrlp_pkg::PH_PATH;
                     count_in = '0;
                     match_in = 1'b1;
                  end else begin
                     decided = 1'b1;
                     st      = hrlp_pkg::ST_NOT_GET;
                  end
               end else if (count_ff >= CNT_W'(hrlp_pkg::METHOD_LIMIT)) begin
                  decided = 1'b1;
                  st      = hrlp_pkg::ST_METHOD_LONG;
               end else begin
                  if (count_ff >= CNT_W'(hrlp_pkg::GET_LEN) ||
                      b != hrlp_pkg::get_char(count_ff[1:0])) begin
                     match_in = 1'b0;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            hrlp_pkg::PH_PATH: begin
               if (b == hrlp_pkg::CHAR_SPACE) begin
                  len_in   = count_ff[LEN_W-1:0];
                  phase_in = hrlp_pkg::PH_VERSION;
                  count_in = '0;
                  match_in = 1'b1;
               end else if (count_ff >= CNT_W'(PATH_LIMIT)) begin
                  decided = 1'b1;
                  st      = hrlp_pkg::ST_PATH_LONG;
               end else begin
                  wr.en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            hrlp_pkg::PH_VERSION: begin
               if (b == hrlp_pkg::CHAR_SPACE || b == hrlp_pkg::CHAR_CR) begin
                  decided = 1'b1;
                  if (!(match_ff && count_ff == CNT_W'(hrlp_pkg::VERSION_LEN))) begin
                     st = hrlp_pkg::ST_BAD_VERSION;
                  end else if (len_ff == '0) begin
                     st = hrlp_pkg::ST_EMPTY_PATH;
                  end else if (len_ff == LEN_W'(1)) begin
                     st = hrlp_pkg::ST_ROOT;
                  end else begin
                     st         = hrlp_pkg::ST_ASSET;
                     pending_in = 1'b1;
                  end
               end else if (count_ff >= CNT_W'(hrlp_pkg::VERSION_LIMIT)) begin
                  decided = 1'b1;
                  st      = hrlp_pkg::ST_VERSION_LONG;
               end else begin
                  if (count_ff < CNT_W'(hrlp_pkg::PREFIX_LEN)) begin
                     if (b != hrlp_pkg::prefix_char(count_ff[2:0])) begin
                        match_in = 1'b0;
                     end
                  end else if (count_ff == CNT_W'(hrlp_pkg::PREFIX_LEN)) begin
                     if (b != hrlp_pkg::CHAR_ZERO && b != hrlp_pkg::CHAR_ONE) begin
                        match_in = 1'b0;
                     end
                  end else begin
                     match_in = 1'b0;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            hrlp_pkg::PH_DRAIN: begin
               if (eod) begin
                  phase_in = hrlp_pkg::PH_METHOD;
                  count_in = '0;
                  match_in = 1'b1;
                  len_in   = '0;
               end
            end
            default: begin
               phase_in = hrlp_pkg::PH_METHOD;
            end
         endcase

         // The request ended inside a field: length check first.
         if (!decided && eod && phase_ff != hrlp_pkg::PH_DRAIN) begin
            decided = 1'b1;
            case (phase_in)
               hrlp_pkg::PH_METHOD: begin
                  st = (count_in >= CNT_W'(hrlp_pkg::METHOD_LIMIT)) ?
                       hrlp_pkg::ST_METHOD_LONG : hrlp_pkg::ST_METHOD_INCOMPLETE;
               end
               hrlp_pkg::PH_PATH: begin
                  st = (count_in >= CNT_W'(PATH_LIMIT)) ?
                       hrlp_pkg::ST_PATH_LONG : hrlp_pkg::ST_PATH_INCOMPLETE;
               end
               default: begin
                  st = (count_in >= CNT_W'(hrlp_pkg::VERSION_LIMIT)) ?
                       hrlp_pkg::ST_VERSION_LONG : hrlp_pkg::ST_VERSION_INCOMPLETE;
               end
            endcase
         end

         if (decided) begin
            phase_in = eod ? hrlp_pkg::PH_METHOD : hrlp_pkg::PH_DRAIN;
            count_in = '0;
            match_in = 1'b1;
            if (eod) begin
               len_in = '0;
            end
         end
      end
   end

   assign cmd_push             = decided;
   assign cmd_data.status      = st;
   assign cmd_data.path_length = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hrlp_pkg::PH_METHOD;
         count_ff   <= '0;
         match_ff   <= 1'b1;
         len_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         match_ff   <= match_in;
         len_ff     <= len_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

[sv/hrlp_back.sv]
`default_nettype none

module hrlp_back #(
   parameter int  ASSET_MAX = 15,
   parameter int  OUT_DEPTH = 4,
   parameter type CMD_TYPE  = logic,
   parameter type WR_TYPE   = logic
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           cmd_empty,
   input  wire CMD_TYPE                        cmd_data,
   output logic                                cmd_pop,
   input  wire WR_TYPE                         wr,
   output logic                                asset_done,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
   output logic                                out_push,
   output hrlp_pkg::rsp_type                   out_data
);

   localparam int LEN_W = $clog2(ASSET_MAX+2);
   localparam int AW    = $clog2(ASSET_MAX+1);
   localparam int LVL_W = $clog2(OUT_DEPTH+1);

   logic [7:0]        path_mem [ASSET_MAX+1];
   logic [7:0]        rd_data_ff;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [3:0]        s1_status_ff, s1_status_in;
   logic              s1_has_ff, s1_has_in;
   logic              s1_last_ff, s1_last_in;
   logic              room, issue, is_asset, is_last;
   logic [LVL_W:0]    occupancy;

   // Count the result already in flight so the output queue never overflows.
   assign occupancy = {1'b0, out_level} + {{LVL_W{1'b0}}, s1_valid_ff};
   assign room      = occupancy < (LVL_W+1)'(OUT_DEPTH);
   assign issue     = !cmd_empty && room;
   assign is_asset  = (cmd_data.status == hrlp_pkg::ST_ASSET);
   assign is_last   = ((idx_ff + 1'b1) == cmd_data.path_length);

   always_comb begin
      idx_in       = idx_ff;
      cmd_pop      = 1'b0;
      asset_done   = 1'b0;
      s1_valid_in  = issue;
      s1_status_in = cmd_data.status;
      s1_has_in    = is_asset;
      s1_last_in   = is_asset ? is_last : 1'b1;
      if (issue) begin
         if (is_asset && !is_last) begin
            idx_in = idx_ff + 1'b1;
         end else begin
            cmd_pop    = 1'b1;
            asset_done = is_asset;
            idx_in     = LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= LEN_W'(1);
         s1_valid_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_has_ff    <= s1_has_in;
      s1_last_ff   <= s1_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         path_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= path_mem[idx_ff[AW-1:0]];
   end

   assign out_push             = s1_valid_ff;
   assign out_data.status      = s1_status_ff;
   assign out_data.asset_byte  = s1_has_ff ? rd_data_ff : 8'h00;
   assign out_data.has_byte    = s1_has_ff;
   assign out_data.last_result = s1_last_ff;

endmodule

`default_nettype wire

[sv/http_request_line_parser_unit.sv]
// HTTP request line parser.
// Input channel: one transaction per request byte, pushed while full is low, with
// end_of_data set on the final byte of the request. Result channel: a queue read
// through empty and pop; each transaction carries a status and, for an asset path,
// one path character. A request yields one result, or one result per asset
// character with last_result set on the final one.
// The front end takes one byte per cycle while full is low and makes its decision
// on the byte that closes a field or ends the request; the decision waits in a
// two-entry command queue. The back end issues one result per cycle while the
// result queue has room, reading the path store through a registered port, into a
// four-entry result queue; a decision gets there via the command queue and stage s1.
// Bytes of later requests keep flowing during an asset burst, except that the
// front end holds off path bytes until the back end has read the previous path.
// When the result side stops popping, the queues fill and full rises; nothing is
// dropped. Reset (synchronous, active high) empties both queues and rearms the
// parser at the method field; the path store needs no clearing.
`default_nettype none

module http_request_line_parser_unit #(
   parameter int ASSET_MAX = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire hrlp_pkg::request_type req_data,
   output logic                       empty,
   input  wire logic                  pop,
   output hrlp_pkg::rsp_type          rsp_data
);

   localparam int LEN_W     = $clog2(ASSET_MAX+2);
   localparam int AW        = $clog2(ASSET_MAX+1);
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   // Decision handed from the front end to the back end.
   typedef struct packed {
      hrlp_pkg::status_type status;
      logic [LEN_W-1:0]     path_length;
   } cmd_type;

   // Write port of the path store.
   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [7:0]    data;
   } wr_type;

   cmd_type                        front_cmd, back_cmd;
   wr_type                         path_wr;
   logic                           cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic                           asset_done;
   logic                           out_push;
   hrlp_pkg::rsp_type              out_data;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

   hrlp_front #(
      .ASSET_MAX (ASSET_MAX),
      .CMD_TYPE  (cmd_type),
      .WR_TYPE   (wr_type)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_data   (front_cmd),
      .wr         (path_wr),
      .asset_done (asset_done)
   );

   hrlp_queue #(
      .ENTRY_TYPE (cmd_type),
      .DEPTH      (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty),
      .level     ()
   );

   hrlp_back #(
      .ASSET_MAX (ASSET_MAX),
      .OUT_DEPTH (OUT_DEPTH),
      .CMD_TYPE  (cmd_type),
      .WR_TYPE   (wr_type)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_data   (back_cmd),
      .cmd_pop    (cmd_pop),
      .wr         (path_wr),
      .asset_done (asset_done),
      .out_level  (out_level),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   // The back end never pushes without room, so the full flag is not needed here.
   hrlp_queue #(
      .ENTRY_TYPE (hrlp_pkg::rsp_type),
      .DEPTH      (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty),
      .level     (out_level)
   );

endmodule

`default_nettype wire
